// ===== hw/rtl/sdr_pkg.sv =====
package sdr_pkg;

  // Debounce phase, also reported in every tick result.
  typedef enum logic [1:0] {
    PH_INACTIVE    = 2'd0,
    PH_ACTIVE      = 2'd1,
    PH_TRAILING    = 2'd2,
    PH_SUPPRESSING = 2'd3
  } phase_t;

  // Event reported by a tick.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_LEAD   = 3'd1,
    EV_DELAY  = 3'd2,
    EV_TRAIL  = 3'd3,
    EV_REPEAT = 3'd4
  } event_t;

  // Request kind carried on the input tuser.
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_LEVEL = 1'b1
  } opcode_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_TRAIL_TIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAYED_TIME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DEB    = 3'd5;

  // Field widths of the streams.
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 8;

endpackage

// ===== hw/rtl/switch_debouncer_with_repeat_core.sv =====
// Switch debouncer with auto-repeat.
//
// Input stream (in_*): each request is either a level change (tuser high,
// tdata[0] is the raw switch level, 1 pressed) or a time tick (tuser low,
// tdata[16:1] is the number of time units that passed). A level request
// only updates the debounce state and gives no result. A tick advances the
// trailing, suppression, delayed-lead and repeat timers and gives exactly
// one result request: the highest-priority event (leading, delayed lead,
// trailing, repeat, or none) and the phase after the tick.
// Throughput is one request per cycle; a tick's result is presented on the
// output stream in the cycle after the tick is accepted. The whole update
// is one pass of adders and compares into the state and output registers.
// The output register parts the two sides: a new request is accepted while
// a result waits, as long as the receiver takes it in the same cycle. When
// the receiver stalls with a result held, in_tready drops.
// The cfg_* port writes the timing registers; write it only while the
// block is idle. Reset clears the debounce state and configuration to
// zero, phase inactive and result register empty, but sets first_rep_r.
module switch_debouncer_with_repeat_core #(
  parameter int TIME_WIDTH = 32,
  parameter int TICK_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sdr_pkg::IN_DATA_W-1:0]    in_tdata,   // level[0], elapsed[16:1], zero pad
  input  logic                             in_tuser,   // opcode[0]
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sdr_pkg::OUT_DATA_W-1:0]   out_tdata,  // event_res[2:0], phase[4:3], zero pad
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [sdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sdr_pkg::*;

  localparam int TICK_EFF = (TICK_WIDTH < ELAPSED_W) ? TICK_WIDTH : ELAPSED_W;
  localparam int SUM_W = ((TIME_WIDTH > ELAPSED_W) ? TIME_WIDTH : ELAPSED_W) + 1;
  localparam int CMP_W = (TIME_WIDTH > CFG_DATA_W) ? TIME_WIDTH : CFG_DATA_W;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  // Saturating timer advance.
  function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                    input logic [ELAPSED_W-1:0] e);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(e);
    if (s > SUM_W'(TIME_MAX)) return TIME_MAX;
    return s[TIME_WIDTH-1:0];
  endfunction

  function automatic logic cnt_ge(input logic [TIME_WIDTH-1:0] c,
                                  input logic [CFG_DATA_W-1:0] t);
    return CMP_W'(c) >= CMP_W'(t);
  endfunction

  function automatic logic cnt_gt(input logic [TIME_WIDTH-1:0] c,
                                  input logic [CFG_DATA_W-1:0] t);
    return CMP_W'(c) > CMP_W'(t);
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] trail_time_r, suppress_time_r, delayed_time_r;
  logic [CFG_DATA_W-1:0] repeat_first_r, repeat_period_r;
  logic                  repeat_deb_r;

  // Debounce state.
  phase_t                phase_r, phase_nxt;
  logic                  held_level_r, held_level_nxt;
  logic [TIME_WIDTH-1:0] trail_cnt_r, trail_cnt_nxt;
  logic [TIME_WIDTH-1:0] supp_cnt_r, supp_cnt_nxt;
  logic [TIME_WIDTH-1:0] delay_cnt_r, delay_cnt_nxt;
  logic [TIME_WIDTH-1:0] rep_cnt_r, rep_cnt_nxt;
  logic                  delay_run_r, delay_run_nxt;
  logic                  rep_run_r, rep_run_nxt;
  logic                  first_rep_r, first_rep_nxt;
  logic                  pend_lead_r, pend_lead_nxt;
  logic                  pend_delay_r, pend_delay_nxt;
  logic                  pend_trail_r, pend_trail_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  event_t                ev_r, ev_nxt;
  phase_t                out_phase_r, out_phase_nxt;

  logic                  in_acc;
  logic                  lv;
  logic                  held;
  logic [ELAPSED_W-1:0]  elapsed;
  logic                  is_tick;
  logic                  rep_hit;
  logic                  delay_hit;
  logic                  trail_hit;
  logic [TIME_WIDTH-1:0] tc_sum, sc_sum, sc_fresh, dc_sum, rc_sum;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign lv        = in_tdata[0];
  assign elapsed   = ELAPSED_W'(in_tdata[TICK_EFF:1]);
  assign is_tick   = (in_tuser == OP_TICK);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_phase_r, ev_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trail_time_r     <= '0;
      suppress_time_r  <= '0;
      delayed_time_r   <= '0;
      repeat_first_r   <= '0;
      repeat_period_r  <= '0;
      repeat_deb_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRAIL_TIME:    trail_time_r    <= cfg_wdata;
        REG_SUPPRESS_TIME: suppress_time_r <= cfg_wdata;
        REG_DELAYED_TIME:  delayed_time_r  <= cfg_wdata;
        REG_REPEAT_FIRST:  repeat_first_r  <= cfg_wdata;
        REG_REPEAT_PERIOD: repeat_period_r <= cfg_wdata;
        REG_REPEAT_DEB:    repeat_deb_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Timer sums, computed in parallel.
  assign tc_sum   = sat_add(trail_cnt_r, elapsed);
  assign sc_sum   = sat_add(supp_cnt_r, elapsed);
  assign sc_fresh = sat_add('0, elapsed);
  assign dc_sum   = sat_add(delay_cnt_r, elapsed);
  assign rc_sum   = sat_add(rep_cnt_r, elapsed);

  // State update for one request.
  always_comb begin
    phase_nxt      = phase_r;
    held_level_nxt = held_level_r;
    trail_cnt_nxt  = trail_cnt_r;
    supp_cnt_nxt   = supp_cnt_r;
    delay_cnt_nxt  = delay_cnt_r;
    rep_cnt_nxt    = rep_cnt_r;
    delay_run_nxt  = delay_run_r;
    rep_run_nxt    = rep_run_r;
    first_rep_nxt  = first_rep_r;
    pend_lead_nxt  = pend_lead_r;
    pend_delay_nxt = pend_delay_r;
    pend_trail_nxt = pend_trail_r;
    held           = (phase_r != PH_SUPPRESSING) ? lv : held_level_r;
    rep_hit        = 1'b0;
    delay_hit      = 1'b0;
    trail_hit      = 1'b0;
    ev_nxt         = EV_NONE;

    if (in_acc && !is_tick) begin
      // Level change.
      held_level_nxt = held;
      if (held && phase_r == PH_INACTIVE) begin
        phase_nxt     = PH_ACTIVE;
        pend_lead_nxt = 1'b1;
        delay_cnt_nxt = '0;
        delay_run_nxt = 1'b1;
        rep_run_nxt   = 1'b1;
        first_rep_nxt = 1'b1;
        rep_cnt_nxt   = '0;
      end else if (!held && phase_r == PH_ACTIVE) begin
        phase_nxt     = PH_TRAILING;
        trail_cnt_nxt = '0;
        if (!repeat_deb_r) rep_run_nxt = 1'b0;
      end else if (held && phase_r == PH_TRAILING) begin
        phase_nxt     = PH_ACTIVE;
        trail_cnt_nxt = '0;
        if (!repeat_deb_r) begin
          rep_run_nxt   = 1'b1;
          first_rep_nxt = 1'b1;
          rep_cnt_nxt   = '0;
        end
      end else if (phase_r == PH_SUPPRESSING) begin
        held_level_nxt = 1'b0;
      end
    end else if (in_acc && is_tick) begin
      // Trailing timer; expiry leaves trailing on the same tick, for suppression or inactive.
      if (phase_r == PH_TRAILING) begin
        trail_cnt_nxt = tc_sum;
        if (cnt_ge(tc_sum, trail_time_r)) begin
          trail_hit = 1'b1;
          if (repeat_deb_r) rep_run_nxt = 1'b0;
        end
      end
      // Suppression timer, started fresh when trailing just ended.
      if (trail_hit) begin
        supp_cnt_nxt = sc_fresh;
        phase_nxt    = cnt_ge(sc_fresh, suppress_time_r) ? PH_INACTIVE : PH_SUPPRESSING;
      end else if (phase_r == PH_SUPPRESSING) begin
        supp_cnt_nxt = sc_sum;
        if (cnt_ge(sc_sum, suppress_time_r)) phase_nxt = PH_INACTIVE;
      end
      // Delayed-lead timer.
      if (delay_run_r) begin
        delay_cnt_nxt = dc_sum;
        if (cnt_ge(dc_sum, delayed_time_r)) begin
          delay_hit     = 1'b1;
          delay_run_nxt = 1'b0;
        end
      end
      // Repeat timer.
      if (rep_run_nxt) begin
        rep_cnt_nxt = rc_sum;
        if (first_rep_r && cnt_gt(rc_sum, repeat_first_r)) begin
          first_rep_nxt = 1'b0;
          rep_hit       = 1'b1;
          rep_cnt_nxt   = '0;
        end else if (!first_rep_r && cnt_gt(rc_sum, repeat_period_r)) begin
          rep_hit     = 1'b1;
          rep_cnt_nxt = '0;
        end
      end
      // Report one event; the rest are dropped.
      priority if (pend_lead_r)                  ev_nxt = EV_LEAD;
      else if (pend_delay_r || delay_hit)        ev_nxt = EV_DELAY;
      else if (pend_trail_r || trail_hit)        ev_nxt = EV_TRAIL;
      else if (rep_hit)                          ev_nxt = EV_REPEAT;
      else                                       ev_nxt = EV_NONE;
      pend_lead_nxt  = 1'b0;
      pend_delay_nxt = 1'b0;
      pend_trail_nxt = 1'b0;
    end
  end

  // Result register control.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_phase_nxt = out_phase_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (in_acc && is_tick) begin
      out_valid_nxt = 1'b1;
      out_phase_nxt = phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_INACTIVE;
      held_level_r <= 1'b0;
      trail_cnt_r  <= '0;
      supp_cnt_r   <= '0;
      delay_cnt_r  <= '0;
      rep_cnt_r    <= '0;
      delay_run_r  <= 1'b0;
      rep_run_r    <= 1'b0;
      first_rep_r  <= 1'b1;
      pend_lead_r  <= 1'b0;
      pend_delay_r <= 1'b0;
      pend_trail_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      held_level_r <= held_level_nxt;
      trail_cnt_r  <= trail_cnt_nxt;
      supp_cnt_r   <= supp_cnt_nxt;
      delay_cnt_r  <= delay_cnt_nxt;
      rep_cnt_r    <= rep_cnt_nxt;
      delay_run_r  <= delay_run_nxt;
      rep_run_r    <= rep_run_nxt;
      first_rep_r  <= first_rep_nxt;
      pend_lead_r  <= pend_lead_nxt;
      pend_delay_r <= pend_delay_nxt;
      pend_trail_r <= pend_trail_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc && is_tick) ev_r <= ev_nxt;
    out_phase_r <= out_phase_nxt;
  end

`ifndef SYNTH
  // The held level is high exactly while the switch is debounced as active.
  a_held_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    held_level_r == (phase_r == PH_ACTIVE))
    else $error("held level disagrees with phase");

  // An accepted tick always leaves a result in the output register.
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_tick) |=> out_valid_r)
    else $error("tick accepted without a result");

  // A level request never creates a result.
  a_level_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_tick && !out_valid_r) |=> !out_valid_r)
    else $error("level request produced a result");
`endif

endmodule
